// File: rtl/ntp_avg_pkg.sv
package ntp_avg_pkg;

  // Datapath width of timestamps, corrections and sums.
  localparam int DATA_W = 64;

  // Width of the tolerance register.
  localparam int TOL_W = DATA_W - 1;

  // Default bound on the number of corrections averaged per round.
  localparam int MAX_RESPONSES_DEF = 16;

  // Tolerance after reset: half a second in 2^-32 second units.
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(64'd2147483648);

  // Header checks.
  localparam logic [9:0] MIN_LEN      = 10'd48;
  localparam logic [2:0] VER_LOW      = 3'd3;
  localparam logic [2:0] VER_HIGH     = 3'd4;
  localparam logic [2:0] MODE_SERVER  = 3'd4;
  localparam logic [1:0] LEAP_UNKNOWN = 2'd3;

  // Saturation limits of the running sum.
  localparam logic [DATA_W-1:0] SUM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SUM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Per-reply status, first failing check wins.
  typedef enum logic [2:0] {
    RS_OK          = 3'd0,
    RS_ABSENT      = 3'd1,
    RS_SHORT       = 3'd2,
    RS_BAD_VERSION = 3'd3,
    RS_BAD_MODE    = 3'd4,
    RS_LEAP_UNKN   = 3'd5,
    RS_ORIGIN_MISM = 3'd6,
    RS_ZERO_STAMP  = 3'd7
  } reply_status_t;

  // Verdict at the end of a round.
  typedef enum logic [1:0] {
    RND_APPLY     = 2'd0,
    RND_TOLERATE  = 2'd1,
    RND_NO_SERVER = 2'd2
  } round_status_t;

  // Sequencer states; each serial pass walks all DATA_W bits.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CHECK,
    ST_CORR,
    ST_SAT,
    ST_MAG,
    ST_DIV,
    ST_SIGN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/ntp_offset_delay_averager_top.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------
// in_      | input     | in_valid/in_stall  | reply header fields and five timestamps
// out_     | output    | out_valid/out_stall| reply status, correction, latency, round
// cfg_     | input     | cfg_wr_en          | drift tolerance (63 bits)
//
// Every item runs from transfer to a loaded result as two bit-serial passes over all 64 bits
// (round trip, then latency/correction/sum) plus a check and a saturate step.
// An item that closes a round with usable replies adds sum magnitude, a 64-step
// restoring divide by the reply count, and the sign restore, one bit per cycle.
// Reset is synchronous and active low; it clears the sum and the count and sets the
// tolerance to half a second.
// The next item is taken while a result still waits on out_stall; a finished item then
// holds in its last step until the output register frees up.
module ntp_offset_delay_averager_top
  import ntp_avg_pkg::*;
#(
  parameter int MAX_RESPONSES = MAX_RESPONSES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration.
  input  logic                     cfg_wr_en,
  input  logic [TOL_W-1:0]         cfg_wr_data,
  // Reply input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_reply_present,
  input  logic [DATA_W-1:0]        in_request_sent_time,
  input  logic [DATA_W-1:0]        in_echoed_origin_time,
  input  logic [DATA_W-1:0]        in_server_receive_time,
  input  logic [DATA_W-1:0]        in_server_transmit_time,
  input  logic [DATA_W-1:0]        in_local_arrival_time,
  input  logic [9:0]               in_reply_length,
  input  logic [2:0]               in_version_field,
  input  logic [2:0]               in_mode_field,
  input  logic [1:0]               in_leap_field,
  input  logic                     in_last_response,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_reply_status,
  output logic signed [DATA_W-1:0] out_correction,
  output logic signed [DATA_W-1:0] out_latency,
  output logic                     out_round_done,
  output logic [1:0]               out_round_status,
  output logic signed [DATA_W-1:0] out_average_correction
);

  localparam int CW    = $clog2(MAX_RESPONSES + 1);
  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);
  localparam logic [CW-1:0]    COUNT_MAX = CW'(MAX_RESPONSES);

  // Full-adder carry and full-subtractor borrow for the serial passes.
  function automatic logic maj(input logic x, input logic y, input logic c);
    maj = (x & y) | (x & c) | (y & c);
  endfunction

  function automatic logic borrow(input logic x, input logic y, input logic b);
    borrow = (~x & y) | (~(x ^ y) & b);
  endfunction

  // Control registers.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [DATA_W-1:0] sum_r, sum_nxt;
  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Captured reply.
  logic [DATA_W-1:0] t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt;
  logic [DATA_W-1:0] orig_r, orig_nxt;
  logic              present_r, present_nxt, last_r, last_nxt;
  logic [9:0]        len_r, len_nxt;
  logic [2:0]        ver_r, ver_nxt, mode_r, mode_nxt;
  logic [1:0]        leap_r, leap_nxt;

  // Serial working state.
  logic              mism_r, mism_nxt, t2nz_r, t2nz_nxt, t3nz_r, t3nz_nxt;
  logic [DATA_W-1:0] d_r, d_nxt;
  logic              sgn_d_r, sgn_d_nxt;
  logic [3:0]        car_r, car_nxt;
  reply_status_t     status_r, status_nxt;
  logic              ok_r, ok_nxt, add_en_r, add_en_nxt;
  logic [DATA_W-1:0] lat_r, lat_nxt, corr_r, corr_nxt;
  logic              sgn_sum_r, sgn_sum_nxt, sgn_corr_r, sgn_corr_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0] tcmp_r, tcmp_nxt;
  logic              dec_r, dec_nxt, gt_r, gt_nxt;

  // Output register.
  reply_status_t     o_status_r, o_status_nxt;
  logic [DATA_W-1:0] o_corr_r, o_corr_nxt, o_lat_r, o_lat_nxt, o_avg_r, o_avg_nxt;
  logic              o_done_r, o_done_nxt;
  round_status_t     o_rstat_r, o_rstat_nxt;

  // Sequencer outputs.
  logic in_take;
  logic out_load;

  // Serial bit signals.
  logic          a_bit, b_bit, d_bit, lat_bit, u_bit, c_bit, s_bit, m_bit;
  logic [CW:0]   rem_sh;
  logic          q_ge;
  logic [DATA_W-1:0] sum_fin;
  round_status_t rstat;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (last_r && (add_en_r || count_r != '0)) state_nxt = ST_MAG;
        else state_nxt = ST_DONE;
      end
      ST_MAG: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: begin
        in_stall = 1'b1;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_take = in_valid && !in_stall;

  // Serial datapath.
  always_comb begin
    cnt_nxt      = cnt_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    t1_nxt       = t1_r;
    t2_nxt       = t2_r;
    t3_nxt       = t3_r;
    t4_nxt       = t4_r;
    orig_nxt     = orig_r;
    present_nxt  = present_r;
    last_nxt     = last_r;
    len_nxt      = len_r;
    ver_nxt      = ver_r;
    mode_nxt     = mode_r;
    leap_nxt     = leap_r;
    mism_nxt     = mism_r;
    t2nz_nxt     = t2nz_r;
    t3nz_nxt     = t3nz_r;
    d_nxt        = d_r;
    sgn_d_nxt    = sgn_d_r;
    car_nxt      = car_r;
    status_nxt   = status_r;
    ok_nxt       = ok_r;
    add_en_nxt   = add_en_r;
    lat_nxt      = lat_r;
    corr_nxt     = corr_r;
    sgn_sum_nxt  = sgn_sum_r;
    sgn_corr_nxt = sgn_corr_r;
    neg_nxt      = neg_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    tcmp_nxt     = tcmp_r;
    dec_nxt      = dec_r;
    gt_nxt       = gt_r;
    a_bit        = 1'b0;
    b_bit        = 1'b0;
    d_bit        = 1'b0;
    lat_bit      = 1'b0;
    u_bit        = 1'b0;
    c_bit        = 1'b0;
    s_bit        = 1'b0;
    m_bit        = 1'b0;
    rem_sh       = {rem_r, q_r[DATA_W-1]};
    q_ge         = 1'b0;
    sum_fin      = sum_r;

    case (state_r)
      // Capture the reply on a transfer.
      ST_IDLE: begin
        if (in_take) begin
          present_nxt = in_reply_present;
          t1_nxt      = in_request_sent_time;
          orig_nxt    = in_echoed_origin_time;
          t2_nxt      = in_server_receive_time;
          t3_nxt      = in_server_transmit_time;
          t4_nxt      = in_local_arrival_time;
          len_nxt     = in_reply_length;
          ver_nxt     = in_version_field;
          mode_nxt    = in_mode_field;
          leap_nxt    = in_leap_field;
          last_nxt    = in_last_response;
        end
        cnt_nxt  = '0;
        car_nxt  = '0;
        mism_nxt = 1'b0;
        t2nz_nxt = 1'b0;
        t3nz_nxt = 1'b0;
      end

      // Round trip d = (T4 - T1) - (T3 - T2), LSB first; the last borrow is its sign.
      ST_DIFF: begin
        a_bit      = t4_r[0] ^ t1_r[0] ^ car_r[0];
        b_bit      = t3_r[0] ^ t2_r[0] ^ car_r[1];
        d_bit      = a_bit ^ b_bit ^ car_r[2];
        car_nxt[0] = borrow(t4_r[0], t1_r[0], car_r[0]);
        car_nxt[1] = borrow(t3_r[0], t2_r[0], car_r[1]);
        car_nxt[2] = borrow(a_bit, b_bit, car_r[2]);
        d_nxt      = {d_bit, d_r[DATA_W-1:1]};
        mism_nxt   = mism_r | (orig_r[0] ^ t1_r[0]);
        t2nz_nxt   = t2nz_r | t2_r[0];
        t3nz_nxt   = t3nz_r | t3_r[0];
        t1_nxt     = t1_r >> 1;
        t2_nxt     = t2_r >> 1;
        orig_nxt   = orig_r >> 1;
        t3_nxt     = {t3_r[0], t3_r[DATA_W-1:1]};
        t4_nxt     = {t4_r[0], t4_r[DATA_W-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
      end

      // Header checks in priority order; prime the carries of the next pass.
      ST_CHECK: begin
        if (!present_r) status_nxt = RS_ABSENT;
        else if (len_r < MIN_LEN) status_nxt = RS_SHORT;
        else if (ver_r < VER_LOW || ver_r > VER_HIGH) status_nxt = RS_BAD_VERSION;
        else if (mode_r != MODE_SERVER) status_nxt = RS_BAD_MODE;
        else if (leap_r == LEAP_UNKNOWN) status_nxt = RS_LEAP_UNKN;
        else if (mism_r) status_nxt = RS_ORIGIN_MISM;
        else if (!t2nz_r || !t3nz_r) status_nxt = RS_ZERO_STAMP;
        else status_nxt = RS_OK;
        ok_nxt     = (status_nxt == RS_OK);
        add_en_nxt = ok_nxt && (count_r < COUNT_MAX);
        sgn_d_nxt  = car_r[2];
        // Halving truncates toward zero: add one back when d is negative and odd.
        car_nxt    = {3'b000, car_r[2] & d_r[0]};
        cnt_nxt    = '0;
      end

      // Latency = half of d, correction = T3 + latency - T4, sum += correction if counted.
      ST_CORR: begin
        lat_bit    = d_r[1] ^ car_r[0];
        car_nxt[0] = d_r[1] & car_r[0];
        u_bit      = t3_r[0] ^ lat_bit ^ car_r[1];
        car_nxt[1] = maj(t3_r[0], lat_bit, car_r[1]);
        c_bit      = u_bit ^ t4_r[0] ^ car_r[2];
        car_nxt[2] = borrow(u_bit, t4_r[0], car_r[2]);
        s_bit      = sum_r[0] ^ c_bit ^ car_r[3];
        d_nxt      = {sgn_d_r, d_r[DATA_W-1:1]};
        lat_nxt    = {lat_bit, lat_r[DATA_W-1:1]};
        corr_nxt   = {c_bit, corr_r[DATA_W-1:1]};
        t3_nxt     = t3_r >> 1;
        t4_nxt     = t4_r >> 1;
        if (add_en_r) begin
          car_nxt[3] = maj(sum_r[0], c_bit, car_r[3]);
          sum_nxt    = {s_bit, sum_r[DATA_W-1:1]};
        end else begin
          sum_nxt    = {sum_r[0], sum_r[DATA_W-1:1]};
        end
        if (cnt_r == CNT_LAST) begin
          sgn_sum_nxt  = sum_r[0];
          sgn_corr_nxt = c_bit;
        end
        cnt_nxt = cnt_r + 1'b1;
      end

      // Clamp an overflowed sum and count the reply.
      ST_SAT: begin
        if (add_en_r && (sgn_sum_r == sgn_corr_r) && (sum_r[DATA_W-1] != sgn_sum_r)) begin
          sum_fin = sgn_sum_r ? SUM_MIN : SUM_MAX;
        end
        sum_nxt = sum_fin;
        if (add_en_r) count_nxt = count_r + 1'b1;
        neg_nxt    = sum_fin[DATA_W-1];
        car_nxt    = {3'b000, sum_fin[DATA_W-1]};
        cnt_nxt    = '0;
      end

      // Magnitude of the sum into the dividend register.
      ST_MAG: begin
        m_bit      = sum_r[0] ^ neg_r;
        q_nxt      = {m_bit ^ car_r[0], q_r[DATA_W-1:1]};
        car_nxt[0] = m_bit & car_r[0];
        sum_nxt    = {sum_r[0], sum_r[DATA_W-1:1]};
        rem_nxt    = '0;
        tcmp_nxt   = {1'b0, tol_r};
        dec_nxt    = 1'b0;
        gt_nxt     = 1'b0;
        cnt_nxt    = cnt_r + 1'b1;
      end

      // Restoring divide by the count, quotient MSB first, checked against the tolerance.
      ST_DIV: begin
        q_ge = (rem_sh >= {1'b0, count_r});
        if (q_ge) rem_nxt = CW'(rem_sh - {1'b0, count_r});
        else rem_nxt = rem_sh[CW-1:0];
        q_nxt    = {q_r[DATA_W-2:0], q_ge};
        tcmp_nxt = tcmp_r << 1;
        if (!dec_r && (q_ge != tcmp_r[DATA_W-1])) begin
          dec_nxt = 1'b1;
          gt_nxt  = q_ge;
        end
        car_nxt = {3'b000, neg_r};
        cnt_nxt = cnt_r + 1'b1;
      end

      // Give the quotient the sign of the sum.
      ST_SIGN: begin
        m_bit      = q_r[0] ^ neg_r;
        q_nxt      = {m_bit ^ car_r[0], q_r[DATA_W-1:1]};
        car_nxt[0] = m_bit & car_r[0];
        cnt_nxt    = cnt_r + 1'b1;
      end

      // Hand off the result; a closing item clears the round.
      ST_DONE: begin
        if (out_load && last_r) begin
          sum_nxt   = '0;
          count_nxt = '0;
        end
      end

      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Round verdict and output register.
  always_comb begin
    if (!last_r) rstat = RND_APPLY;
    else if (count_r == '0) rstat = RND_NO_SERVER;
    else if (gt_r) rstat = RND_APPLY;
    else rstat = RND_TOLERATE;

    o_status_nxt = o_status_r;
    o_corr_nxt   = o_corr_r;
    o_lat_nxt    = o_lat_r;
    o_done_nxt   = o_done_r;
    o_rstat_nxt  = o_rstat_r;
    o_avg_nxt    = o_avg_r;
    if (out_load) begin
      o_status_nxt = status_r;
      o_corr_nxt   = ok_r ? corr_r : '0;
      o_lat_nxt    = ok_r ? lat_r : '0;
      o_done_nxt   = last_r;
      o_rstat_nxt  = rstat;
      o_avg_nxt    = (last_r && count_r != '0) ? q_r : '0;
    end

    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;

    if (cfg_wr_en) tol_nxt = cfg_wr_data;
    else tol_nxt = tol_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      tol_r       <= tol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and serial registers.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    t3_r       <= t3_nxt;
    t4_r       <= t4_nxt;
    orig_r     <= orig_nxt;
    present_r  <= present_nxt;
    last_r     <= last_nxt;
    len_r      <= len_nxt;
    ver_r      <= ver_nxt;
    mode_r     <= mode_nxt;
    leap_r     <= leap_nxt;
    mism_r     <= mism_nxt;
    t2nz_r     <= t2nz_nxt;
    t3nz_r     <= t3nz_nxt;
    d_r        <= d_nxt;
    sgn_d_r    <= sgn_d_nxt;
    car_r      <= car_nxt;
    status_r   <= status_nxt;
    ok_r       <= ok_nxt;
    add_en_r   <= add_en_nxt;
    lat_r      <= lat_nxt;
    corr_r     <= corr_nxt;
    sgn_sum_r  <= sgn_sum_nxt;
    sgn_corr_r <= sgn_corr_nxt;
    neg_r      <= neg_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    tcmp_r     <= tcmp_nxt;
    dec_r      <= dec_nxt;
    gt_r       <= gt_nxt;
    o_status_r <= o_status_nxt;
    o_corr_r   <= o_corr_nxt;
    o_lat_r    <= o_lat_nxt;
    o_done_r   <= o_done_nxt;
    o_rstat_r  <= o_rstat_nxt;
    o_avg_r    <= o_avg_nxt;
  end

  // Ports.
  assign out_valid              = out_valid_r;
  assign out_reply_status       = o_status_r;
  assign out_correction         = o_corr_r;
  assign out_latency            = o_lat_r;
  assign out_round_done         = o_done_r;
  assign out_round_status       = o_rstat_r;
  assign out_average_correction = o_avg_r;

  // The reply count never passes its bound.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("reply count above its bound");

  // A new result only appears after the hand-off step.
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the hand-off step");

  // A rejected reply carries no correction and no latency.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r != RS_OK) |-> (o_corr_r == '0 && o_lat_r == '0))
    else $error("rejected reply with nonzero correction or latency");

  // Round fields stay zero off a round end.
  a_round_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_done_r) |-> (o_rstat_r == RND_APPLY && o_avg_r == '0))
    else $error("round fields set on a result that does not close a round");

  // Closing a round clears the sum and the count.
  a_round_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (count_r == '0 && sum_r == '0))
    else $error("round state not cleared at round end");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ntp_avg_pkg::*;

  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 3000;

  // One server reply as it crosses the input channel.
  typedef struct {
    logic        present;
    logic [63:0] sent;
    logic [63:0] origin;
    logic [63:0] srv_rx;
    logic [63:0] srv_tx;
    logic [63:0] arrival;
    logic [9:0]  len;
    logic [2:0]  ver;
    logic [2:0]  mode;
    logic [1:0]  leap;
    logic        last;
  } reply_t;

  // Expected content of one result transfer.
  typedef struct {
    reply_status_t status;
    logic [63:0]   corr;
    logic [63:0]   lat;
    logic          done;
    round_status_t rstat;
    logic [63:0]   avg;
  } verdict_t;

  // Directed stimulus row; typed rows carry their own expected result.
  typedef struct {
    reply_t   item;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [TOL_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic in_reply_present;
  logic [DATA_W-1:0] in_request_sent_time;
  logic [DATA_W-1:0] in_echoed_origin_time;
  logic [DATA_W-1:0] in_server_receive_time;
  logic [DATA_W-1:0] in_server_transmit_time;
  logic [DATA_W-1:0] in_local_arrival_time;
  logic [9:0] in_reply_length;
  logic [2:0] in_version_field;
  logic [2:0] in_mode_field;
  logic [1:0] in_leap_field;
  logic in_last_response;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_reply_status;
  logic signed [DATA_W-1:0] out_correction;
  logic signed [DATA_W-1:0] out_latency;
  logic out_round_done;
  logic [1:0] out_round_status;
  logic signed [DATA_W-1:0] out_average_correction;

  // Shadow of the block's state and tolerance register.
  logic [63:0] acc_sum;
  int acc_count;
  logic [TOL_W-1:0] tol_model;

  verdict_t pending_verdicts[$];
  dir_row_t dir_rows[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  ntp_offset_delay_averager_top #(
    .MAX_RESPONSES(MAX_RESPONSES_DEF)
  ) u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_reply_present        (in_reply_present),
    .in_request_sent_time    (in_request_sent_time),
    .in_echoed_origin_time   (in_echoed_origin_time),
    .in_server_receive_time  (in_server_receive_time),
    .in_server_transmit_time (in_server_transmit_time),
    .in_local_arrival_time   (in_local_arrival_time),
    .in_reply_length         (in_reply_length),
    .in_version_field        (in_version_field),
    .in_mode_field           (in_mode_field),
    .in_leap_field           (in_leap_field),
    .in_last_response        (in_last_response),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_reply_status        (out_reply_status),
    .out_correction          (out_correction),
    .out_latency             (out_latency),
    .out_round_done          (out_round_done),
    .out_round_status        (out_round_status),
    .out_average_correction  (out_average_correction)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // Appends one expected result behind those still waiting.
  function automatic void queue_verdict(verdict_t v);
    pending_verdicts = {pending_verdicts, v};
  endfunction

  // A reply that passes every header check, with the given timestamps.
  function automatic reply_t good_reply(logic [63:0] sent, logic [63:0] rx,
                                        logic [63:0] tx, logic [63:0] arrival);
    reply_t r;
    r.present = 1'b1;
    r.sent    = sent;
    r.origin  = sent;
    r.srv_rx  = rx;
    r.srv_tx  = tx;
    r.arrival = arrival;
    r.len     = MIN_LEN;
    r.ver     = VER_HIGH;
    r.mode    = MODE_SERVER;
    r.leap    = 2'd0;
    r.last    = 1'b0;
    return r;
  endfunction

  // Result with zero numeric fields; a closing row is assumed to end an empty round.
  function automatic verdict_t plain_verdict(reply_status_t status, logic last);
    verdict_t v;
    v.status = status;
    v.corr   = '0;
    v.lat    = '0;
    v.done   = last;
    v.rstat  = last ? RND_NO_SERVER : RND_APPLY;
    v.avg    = '0;
    return v;
  endfunction

  // Validates one reply, updates the running sum and count, and closes the round on a last reply.
  function automatic verdict_t predict_reply(reply_t r);
    verdict_t v;
    logic [63:0] fwd, srv, sum_next, mag, quo;
    v.corr  = '0;
    v.lat   = '0;
    v.done  = r.last;
    v.rstat = RND_APPLY;
    v.avg   = '0;
    if (!r.present) v.status = RS_ABSENT;
    else if (r.len < MIN_LEN) v.status = RS_SHORT;
    else if (r.ver < VER_LOW || r.ver > VER_HIGH) v.status = RS_BAD_VERSION;
    else if (r.mode != MODE_SERVER) v.status = RS_BAD_MODE;
    else if (r.leap == LEAP_UNKNOWN) v.status = RS_LEAP_UNKN;
    else if (r.origin != r.sent) v.status = RS_ORIGIN_MISM;
    else if (r.srv_rx == '0 || r.srv_tx == '0) v.status = RS_ZERO_STAMP;
    else v.status = RS_OK;

    if (v.status == RS_OK) begin
      // Half the round trip, truncated toward zero, then the wrapped offset.
      fwd = r.arrival - r.sent;
      srv = r.srv_tx - r.srv_rx;
      v.lat = (fwd >= srv) ? (fwd - srv) >> 1 : '0 - ((srv - fwd) >> 1);
      v.corr = r.srv_tx + v.lat - r.arrival;
      if (acc_count < MAX_RESPONSES_DEF) begin
        sum_next = acc_sum + v.corr;
        if (acc_sum[63] == v.corr[63] && sum_next[63] != acc_sum[63])
          sum_next = acc_sum[63] ? SUM_MIN : SUM_MAX;
        acc_sum = sum_next;
        acc_count++;
      end
    end

    if (r.last) begin
      if (acc_count == 0) begin
        v.rstat = RND_NO_SERVER;
      end else begin
        mag = acc_sum[63] ? '0 - acc_sum : acc_sum;
        quo = mag / 64'(acc_count);
        v.avg = acc_sum[63] ? '0 - quo : quo;
        v.rstat = (quo <= {1'b0, tol_model}) ? RND_TOLERATE : RND_APPLY;
      end
      acc_sum = '0;
      acc_count = 0;
    end
    return v;
  endfunction

  // Well-formed reply with random content, or, at the given rate, with one defect or noise in every field.
  function automatic reply_t random_reply(logic last, int bad_pct);
    reply_t r;
    logic signed [63:0] off;
    reply_status_t defect;
    off = $signed(rand64()) >>> $urandom_range(24, 63);
    r = good_reply(rand64(), '0, '0, '0);
    if ($urandom_range(0, 4) == 0) begin
      r.srv_rx  = rand64();
      r.srv_tx  = rand64();
      r.arrival = rand64();
    end else begin
      r.srv_rx  = r.sent + off + $urandom;
      r.srv_tx  = r.srv_rx + ($urandom >> 8);
      r.arrival = r.srv_tx - off + $urandom;
    end
    if (r.srv_rx == '0) r.srv_rx = 64'd1;
    if (r.srv_tx == '0) r.srv_tx = 64'd1;
    r.len  = ($urandom_range(0, 3) == 0) ? MIN_LEN : 10'($urandom_range(48, 1023));
    r.ver  = $urandom_range(0, 1) ? VER_LOW : VER_HIGH;
    r.leap = 2'($urandom_range(0, 2));
    r.last = last;
    if ($urandom_range(1, 100) <= bad_pct) begin
      defect = reply_status_t'($urandom_range(0, 7));
      case (defect)
        // Plain noise in every field.
        RS_OK: begin
          r.present = 1'($urandom);
          r.sent    = rand64();
          r.origin  = $urandom_range(0, 1) ? r.sent : rand64();
          r.srv_rx  = rand64();
          r.srv_tx  = rand64();
          r.arrival = rand64();
          r.len     = 10'($urandom);
          r.ver     = 3'($urandom);
          r.mode    = 3'($urandom);
          r.leap    = 2'($urandom);
        end
        RS_ABSENT: r.present = 1'b0;
        RS_SHORT: r.len = 10'($urandom_range(0, 47));
        RS_BAD_VERSION: r.ver = 3'($urandom_range(5, 10));
        RS_BAD_MODE: r.mode = 3'($urandom_range(5, 11));
        RS_LEAP_UNKN: r.leap = LEAP_UNKNOWN;
        RS_ORIGIN_MISM: begin
          r.origin = rand64();
          if (r.origin == r.sent) r.origin = ~r.sent;
        end
        RS_ZERO_STAMP: begin
          if ($urandom_range(0, 1)) r.srv_rx = '0;
          else r.srv_tx = '0;
        end
      endcase
    end
    return r;
  endfunction

  // Drives one reply after a random gap and queues its expected result on transfer.
  task automatic transfer_reply(input reply_t r, input bit typed, input verdict_t want);
    int gap;
    verdict_t v;
    if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                <= 1'b1;
    in_reply_present        <= r.present;
    in_request_sent_time    <= r.sent;
    in_echoed_origin_time   <= r.origin;
    in_server_receive_time  <= r.srv_rx;
    in_server_transmit_time <= r.srv_tx;
    in_local_arrival_time   <= r.arrival;
    in_reply_length         <= r.len;
    in_version_field        <= r.ver;
    in_mode_field           <= r.mode;
    in_leap_field           <= r.leap;
    in_last_response        <= r.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    v = predict_reply(r);
    queue_verdict(typed ? want : v);
  endtask

  // Waits until every expected result has been taken, then lets the block settle.
  task automatic settle_results(input int cycles);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    settle_results(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tol_model = value;
  endtask

  function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
    return 1;
  endfunction

  // Main sequence: reset, directed table, then random rounds under several tolerances.
  initial begin : stimulus
    reply_t r, base;
    logic [TOL_W-1:0] tol_plan[6];
    verdict_t v;
    int kind, n, bad_pct, sent;

    rst_n                   <= 1'b0;
    cfg_wr_en               <= 1'b0;
    cfg_wr_data             <= '0;
    in_valid                <= 1'b0;
    in_reply_present        <= 1'b0;
    in_request_sent_time    <= '0;
    in_echoed_origin_time   <= '0;
    in_server_receive_time  <= '0;
    in_server_transmit_time <= '0;
    in_local_arrival_time   <= '0;
    in_reply_length         <= '0;
    in_version_field        <= '0;
    in_mode_field           <= '0;
    in_leap_field           <= '0;
    in_last_response        <= 1'b0;
    acc_sum   = '0;
    acc_count = 0;
    tol_model = TOL_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Absent reply with every other field at its maximum closes an empty round.
    r = good_reply('1, '1, '1, '1);
    r.present = 1'b0;
    r.len  = '1;
    r.ver  = '1;
    r.mode = '1;
    r.leap = '1;
    r.last = 1'b1;
    add_row('{r, 1'b1, plain_verdict(RS_ABSENT, 1'b1)});

    // Header rejections; where two checks fail, the earlier one wins.
    base = good_reply(64'h1_0000_0000, 64'h2_0000_0000, 64'h2_0000_1000, 64'h3_0000_0000);
    r = base; r.len = '0;
    add_row('{r, 1'b1, plain_verdict(RS_SHORT, 1'b0)});
    r = base; r.len = 10'd47; r.ver = 3'd7;
    add_row('{r, 1'b1, plain_verdict(RS_SHORT, 1'b0)});
    r = base; r.ver = 3'd2;
    add_row('{r, 1'b1, plain_verdict(RS_BAD_VERSION, 1'b0)});
    r = base; r.ver = 3'd5;
    add_row('{r, 1'b1, plain_verdict(RS_BAD_VERSION, 1'b0)});
    r = base; r.ver = '0;
    add_row('{r, 1'b1, plain_verdict(RS_BAD_VERSION, 1'b0)});
    r = base; r.mode = 3'd3; r.leap = LEAP_UNKNOWN;
    add_row('{r, 1'b1, plain_verdict(RS_BAD_MODE, 1'b0)});
    r = base; r.leap = LEAP_UNKNOWN;
    add_row('{r, 1'b1, plain_verdict(RS_LEAP_UNKN, 1'b0)});
    r = base; r.origin = base.sent ^ 64'd1;
    add_row('{r, 1'b1, plain_verdict(RS_ORIGIN_MISM, 1'b0)});
    r = base; r.srv_rx = '0;
    add_row('{r, 1'b1, plain_verdict(RS_ZERO_STAMP, 1'b0)});
    r = base; r.srv_tx = '0;
    add_row('{r, 1'b1, plain_verdict(RS_ZERO_STAMP, 1'b0)});

    // Accepted replies: version 3, longest length, all-ones stamps, negative round trip.
    r = base; r.ver = VER_LOW; r.len = '1; r.leap = 2'd2;
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});
    r = good_reply('1, '1, '1, '1);
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});
    r = good_reply('0, 64'd1, '1, '0); r.last = 1'b1;
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});

    // Exactly half an era folds negative; two of them pin the sum at its minimum,
    // and an absent last reply still closes the round.
    r = good_reply(64'd5, SUM_MIN + 64'd5, SUM_MIN + 64'd5, 64'd5);
    v = plain_verdict(RS_OK, 1'b0);
    v.corr = SUM_MIN;
    add_row('{r, 1'b1, v});
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});
    r.present = 1'b0; r.last = 1'b1;
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});

    // Largest positive correction, saturating high over three replies.
    r = good_reply(64'd1, SUM_MIN, SUM_MIN, 64'd1);
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});
    r.last = 1'b1;
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});

    // Zero correction within tolerance, then a round with no usable server.
    r = good_reply(64'd100, 64'd200, 64'd200, 64'd300); r.last = 1'b1;
    add_row('{r, 1'b0, plain_verdict(RS_OK, 1'b0)});
    r = base; r.leap = LEAP_UNKNOWN; r.last = 1'b1;
    add_row('{r, 1'b1, plain_verdict(RS_LEAP_UNKN, 1'b1)});

    foreach (dir_rows[i]) transfer_reply(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Tolerance settings: zero, maximum, one, a full random value, and scales near typical averages.
    tol_plan[0] = '0;
    tol_plan[1] = '1;
    tol_plan[2] = TOL_W'(rand64() >> $urandom_range(29, 36));
    tol_plan[3] = TOL_W'(rand64());
    tol_plan[4] = TOL_W'(1);
    tol_plan[5] = TOL_W'(rand64() >> $urandom_range(30, 34));

    foreach (tol_plan[p]) begin
      write_tolerance(tol_plan[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Long rounds overflow the count; short all-broken rounds leave it empty.
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
          n = $urandom_range(15, 22);
          bad_pct = 5;
        end else if (kind == 2) begin
          n = $urandom_range(1, 3);
          bad_pct = 100;
        end else begin
          n = $urandom_range(1, 6);
          bad_pct = 25;
        end
        for (int i = 0; i < n; i++)
          transfer_reply(random_reply(i == n - 1, bad_pct), 1'b0, plain_verdict(RS_OK, 1'b0));
        sent += n;
      end
    end

    settle_results(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, sometimes held over a waiting result.
  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 1)) begin
          do @(posedge clk); while (out_valid !== 1'b1);
        end
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with nothing expected, reply_status %0d", out_reply_status);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        mismatches += field_bad("reply_status", want.status, out_reply_status);
        mismatches += field_bad("correction", want.corr, out_correction);
        mismatches += field_bad("latency", want.lat, out_latency);
        mismatches += field_bad("round_done", want.done, out_round_done);
        mismatches += field_bad("round_status", want.rstat, out_round_status);
        mismatches += field_bad("average_correction", want.avg, out_average_correction);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: ntp_offset_delay_averager_top.f
rtl/ntp_avg_pkg.sv
rtl/ntp_offset_delay_averager_top.sv
sim/testbench.sv
